FILE: src/mtm_pkg.sv
// Shared constants, codes and control types of the timeslot merger.
`timescale 1ns / 1ps
package mtm_pkg;

  localparam int NUM_PERIODS_DEF = 4;
  localparam int PERIOD_BITS_DEF = 16;
  localparam int COUNT_BITS_DEF  = 32;

  localparam int REG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int SLOT_W    = 48;
  localparam int DEN_W     = 16;
  localparam int PROD_W    = 64;
  localparam int DIVS_W    = 32;
  localparam int IDX_MAX_W = 2;
  localparam int GK_W      = 5;
  localparam int IN_W      = 32;
  localparam int OUT_W     = 72;

  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] OP_NONE      = 5'd0;
  localparam logic [OP_W-1:0] OP_LOAD_IN   = 5'd1;
  localparam logic [OP_W-1:0] OP_RB_ENTRY  = 5'd2;
  localparam logic [OP_W-1:0] OP_MUL_PAIR  = 5'd3;
  localparam logic [OP_W-1:0] OP_PAIR_DONE = 5'd4;
  localparam logic [OP_W-1:0] OP_MUL_REST  = 5'd5;
  localparam logic [OP_W-1:0] OP_SET_KEEP  = 5'd6;
  localparam logic [OP_W-1:0] OP_SET_DROP  = 5'd7;
  localparam logic [OP_W-1:0] OP_MUL_N     = 5'd8;
  localparam logic [OP_W-1:0] OP_MUL_CMP   = 5'd9;
  localparam logic [OP_W-1:0] OP_BEST      = 5'd10;
  localparam logic [OP_W-1:0] OP_FIRE      = 5'd11;
  localparam logic [OP_W-1:0] OP_GCD_LOAD  = 5'd12;
  localparam logic [OP_W-1:0] OP_GCD_STEP  = 5'd13;
  localparam logic [OP_W-1:0] OP_GCD_FIN   = 5'd14;
  localparam logic [OP_W-1:0] OP_NUM_DONE  = 5'd15;
  localparam logic [OP_W-1:0] OP_DEN_DONE  = 5'd16;
  localparam logic [OP_W-1:0] OP_MUL_QRY   = 5'd17;
  localparam logic [OP_W-1:0] OP_QRY_DONE  = 5'd18;
  localparam logic [OP_W-1:0] OP_OUT       = 5'd19;

  localparam logic [1:0] DV_PROD = 2'd0;
  localparam logic [1:0] DV_GCD  = 2'd1;
  localparam logic [1:0] DV_NUM  = 2'd2;
  localparam logic [1:0] DV_DEN  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_SAT   = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic [IDX_MAX_W-1:0] idx;
    logic                 div_start;
    logic [1:0]           div_sel;
  } mtm_cmd_t;

  typedef struct packed {
    logic mode;
    logic dn_zero;
    logic kept_empty;
    logic on;
    logic kept;
    logic lt;
    logic div_done;
    logic gcd_zero;
    logic drop;
  } mtm_sts_t;

endpackage

FILE: src/mtm_div.sv
// Iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module mtm_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [mtm_pkg::PROD_W-1:0]    dividend,
  input  logic [mtm_pkg::DIVS_W-1:0]    divisor,
  output logic [mtm_pkg::PROD_W-1:0]    quotient,
  output logic [mtm_pkg::DIVS_W-1:0]    remainder,
  output logic                          done
);
  localparam int CNT_W = $clog2(mtm_pkg::PROD_W);

  logic                         busy_r, busy_nxt;
  logic                         done_r, done_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic [mtm_pkg::PROD_W-1:0]   quo_r, quo_nxt;
  logic [mtm_pkg::DIVS_W-1:0]   rem_r, rem_nxt;
  logic [mtm_pkg::DIVS_W-1:0]   dvs_r, dvs_nxt;
  logic [mtm_pkg::DIVS_W:0]     trial;

  assign trial = {rem_r, quo_r[mtm_pkg::PROD_W-1]};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = done_r;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = mtm_pkg::DIVS_W'(trial - {1'b0, dvs_r});
        quo_nxt = {quo_r[mtm_pkg::PROD_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[mtm_pkg::DIVS_W-1:0];
        quo_nxt = {quo_r[mtm_pkg::PROD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(mtm_pkg::PROD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign quotient  = quo_r;
  assign remainder = rem_r;
  assign done      = done_r;
endmodule

FILE: src/mtm_dp.sv
// Datapath: period table, counters, slot, multipliers, gcd and divider.
`timescale 1ns / 1ps
module mtm_dp #(
  parameter int NUM_PERIODS = mtm_pkg::NUM_PERIODS_DEF,
  parameter int PERIOD_BITS = mtm_pkg::PERIOD_BITS_DEF,
  parameter int COUNT_BITS  = mtm_pkg::COUNT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [mtm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mtm_pkg::REG_W-1:0]        cfg_wdata,
  input  logic [mtm_pkg::IN_W-1:0]         in_tdata,
  input  logic [0:0]                       in_tuser,
  input  mtm_pkg::mtm_cmd_t                cmd,
  output mtm_pkg::mtm_sts_t                sts,
  output logic [mtm_pkg::OUT_W-1:0]        out_word
);
  localparam int N     = NUM_PERIODS;
  localparam int P     = PERIOD_BITS;
  localparam int C     = COUNT_BITS;
  localparam int IDX_W = $clog2(N);
  localparam logic [C-1:0] CNT_MAX = '1;
  localparam int SW = mtm_pkg::SLOT_W;
  localparam int DW = mtm_pkg::DEN_W;
  localparam int PW = mtm_pkg::PROD_W;
  localparam int VW = mtm_pkg::DIVS_W;

  logic [P-1:0]  num_r [N];
  logic [P-1:0]  num_nxt [N];
  logic [P-1:0]  den_r [N];
  logic [P-1:0]  den_nxt [N];
  logic [C-1:0]  cnt_r [N];
  logic [C-1:0]  cnt_nxt [N];
  logic [N-1:0]  kept_r, kept_nxt;
  logic [SW-1:0] slot_num_r, slot_num_nxt;
  logic [DW-1:0] slot_den_r, slot_den_nxt;
  logic          mode_r, mode_nxt;
  logic [DW-1:0] dn_r, dn_nxt;
  logic [DW-1:0] dd_r, dd_nxt;
  logic [P-1:0]  ni_r, ni_nxt;
  logic [P-1:0]  di_r, di_nxt;
  logic          drop_r, drop_nxt;
  logic [PW-1:0] p1_r, p1_nxt;
  logic [PW-1:0] p2_r, p2_nxt;
  logic [SW-1:0] nk_r, nk_nxt;
  logic [SW-1:0] bn_r, bn_nxt;
  logic [DW-1:0] bd_r, bd_nxt;
  logic          best_v_r, best_v_nxt;
  logic [N-1:0]  fired_r, fired_nxt;
  logic          sat_r, sat_nxt;
  logic          hit_r, hit_nxt;
  logic [DW-1:0] ga_r, ga_nxt;
  logic [DW-1:0] gb_r, gb_nxt;
  logic [mtm_pkg::GK_W-1:0] gk_r, gk_nxt;
  logic [DW-1:0] g_r, g_nxt;
  logic [mtm_pkg::OUT_W-1:0] out_r, out_nxt;

  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] cfg_ent;
  logic             cfg_hit;
  logic [P-1:0]     cfg_val;
  logic [SW-1:0]    a1, a2;
  logic [DW-1:0]    b1, b2;
  logic [PW-1:0]    prod1, prod2;
  logic [PW-1:0]    div_a;
  logic [VW-1:0]    div_b;
  logic [PW-1:0]    div_q;
  logic [VW-1:0]    div_r;
  logic             div_done;
  logic [DW-1:0]    in_dd;
  logic [1:0]       st_code;

  assign idx     = cmd.idx[IDX_W-1:0];
  assign cfg_ent = cfg_index[IDX_W:1];
  assign cfg_hit = cfg_we && (int'(cfg_index[mtm_pkg::CFG_IDX_W-1:1]) < N);
  assign cfg_val = cfg_wdata[P-1:0];
  assign in_dd   = (in_tdata[31:16] == '0) ? DW'(1) : in_tdata[31:16];

  always_comb begin
    a1 = '0;
    b1 = '0;
    a2 = '0;
    b2 = '0;
    case (cmd.op)
      mtm_pkg::OP_MUL_PAIR: begin
        a1 = SW'(ni_r);
        b1 = DW'(den_r[idx]);
        a2 = SW'(num_r[idx]);
        b2 = DW'(di_r);
      end
      mtm_pkg::OP_MUL_REST: begin
        a1 = slot_num_r;
        b1 = DW'(di_r);
        a2 = SW'(slot_den_r);
        b2 = DW'(ni_r);
      end
      mtm_pkg::OP_MUL_N: begin
        a1 = SW'(cnt_r[idx]);
        b1 = DW'(num_r[idx]);
      end
      mtm_pkg::OP_MUL_CMP: begin
        a1 = nk_r;
        b1 = bd_r;
        a2 = bn_r;
        b2 = DW'(den_r[idx]);
      end
      mtm_pkg::OP_MUL_QRY: begin
        a1 = slot_num_r;
        b1 = dd_r;
        a2 = SW'(slot_den_r);
        b2 = dn_r;
      end
      default: begin
        a1 = '0;
      end
    endcase
  end

  assign prod1 = PW'(a1) * PW'(b1);
  assign prod2 = PW'(a2) * PW'(b2);

  always_comb begin
    case (cmd.div_sel)
      mtm_pkg::DV_PROD: begin
        div_a = p1_r;
        div_b = p2_r[VW-1:0];
      end
      mtm_pkg::DV_GCD: begin
        div_a = PW'(bn_r);
        div_b = VW'(bd_r);
      end
      mtm_pkg::DV_NUM: begin
        div_a = PW'(bn_r);
        div_b = VW'(g_r);
      end
      default: begin
        div_a = PW'(bd_r);
        div_b = VW'(g_r);
      end
    endcase
  end

  mtm_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .quotient  (div_q),
    .remainder (div_r),
    .done      (div_done)
  );

  assign st_code = (kept_r == '0) ? mtm_pkg::ST_EMPTY :
                   (sat_r ? mtm_pkg::ST_SAT : mtm_pkg::ST_OK);

  always_comb begin
    num_nxt      = num_r;
    den_nxt      = den_r;
    cnt_nxt      = cnt_r;
    kept_nxt     = kept_r;
    slot_num_nxt = slot_num_r;
    slot_den_nxt = slot_den_r;
    mode_nxt     = mode_r;
    dn_nxt       = dn_r;
    dd_nxt       = dd_r;
    ni_nxt       = ni_r;
    di_nxt       = di_r;
    drop_nxt     = drop_r;
    p1_nxt       = p1_r;
    p2_nxt       = p2_r;
    nk_nxt       = nk_r;
    bn_nxt       = bn_r;
    bd_nxt       = bd_r;
    best_v_nxt   = best_v_r;
    fired_nxt    = fired_r;
    sat_nxt      = sat_r;
    hit_nxt      = hit_r;
    ga_nxt       = ga_r;
    gb_nxt       = gb_r;
    gk_nxt       = gk_r;
    g_nxt        = g_r;
    out_nxt      = out_r;

    if (cfg_hit) begin
      if (cfg_index[0]) begin
        den_nxt[cfg_ent] = (cfg_val == '0) ? P'(1) : cfg_val;
      end else begin
        num_nxt[cfg_ent] = cfg_val;
      end
    end

    case (cmd.op)
      mtm_pkg::OP_LOAD_IN: begin
        mode_nxt   = in_tuser[0];
        dn_nxt     = in_tdata[15:0];
        dd_nxt     = in_dd;
        fired_nxt  = '0;
        sat_nxt    = 1'b0;
        hit_nxt    = 1'b0;
        best_v_nxt = 1'b0;
      end
      mtm_pkg::OP_RB_ENTRY: begin
        ni_nxt   = num_r[idx];
        di_nxt   = den_r[idx];
        drop_nxt = 1'b0;
      end
      mtm_pkg::OP_MUL_PAIR, mtm_pkg::OP_MUL_REST,
      mtm_pkg::OP_MUL_CMP, mtm_pkg::OP_MUL_QRY: begin
        p1_nxt = prod1;
        p2_nxt = prod2;
      end
      mtm_pkg::OP_PAIR_DONE: begin
        if (div_r == '0) begin
          drop_nxt = 1'b1;
        end
      end
      mtm_pkg::OP_SET_KEEP: begin
        kept_nxt[idx] = 1'b1;
        cnt_nxt[idx]  = (div_q >= PW'(CNT_MAX)) ? CNT_MAX : (C'(div_q) + 1'b1);
      end
      mtm_pkg::OP_SET_DROP: begin
        kept_nxt[idx] = 1'b0;
        cnt_nxt[idx]  = C'(1);
      end
      mtm_pkg::OP_MUL_N: begin
        nk_nxt = prod1[SW-1:0];
      end
      mtm_pkg::OP_BEST: begin
        if (!best_v_r || (p1_r < p2_r)) begin
          bn_nxt     = nk_r;
          bd_nxt     = DW'(den_r[idx]);
          best_v_nxt = 1'b1;
        end
      end
      mtm_pkg::OP_FIRE: begin
        if (p1_r == p2_r) begin
          fired_nxt[idx] = 1'b1;
          if (cnt_r[idx] == CNT_MAX) begin
            sat_nxt = 1'b1;
          end else begin
            cnt_nxt[idx] = cnt_r[idx] + 1'b1;
          end
        end
      end
      mtm_pkg::OP_GCD_LOAD: begin
        ga_nxt = div_r[DW-1:0];
        gb_nxt = bd_r;
        gk_nxt = '0;
      end
      mtm_pkg::OP_GCD_STEP: begin
        if (!ga_r[0] && !gb_r[0]) begin
          ga_nxt = ga_r >> 1;
          gb_nxt = gb_r >> 1;
          gk_nxt = gk_r + 1'b1;
        end else if (!ga_r[0]) begin
          ga_nxt = ga_r >> 1;
        end else if (!gb_r[0]) begin
          gb_nxt = gb_r >> 1;
        end else if (ga_r >= gb_r) begin
          ga_nxt = (ga_r - gb_r) >> 1;
        end else begin
          gb_nxt = (gb_r - ga_r) >> 1;
        end
      end
      mtm_pkg::OP_GCD_FIN: begin
        g_nxt = gb_r << gk_r;
      end
      mtm_pkg::OP_NUM_DONE: begin
        slot_num_nxt = div_q[SW-1:0];
      end
      mtm_pkg::OP_DEN_DONE: begin
        slot_den_nxt = div_q[DW-1:0];
      end
      mtm_pkg::OP_QRY_DONE: begin
        hit_nxt = (div_r == '0);
      end
      mtm_pkg::OP_OUT: begin
        out_nxt = {1'b0, st_code, hit_r, 4'(fired_r), slot_den_r, slot_num_r};
      end
      default: begin
        out_nxt = out_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < N; k++) begin
        num_r[k] <= (k == 0) ? P'(1) : '0;
        den_r[k] <= P'(1);
        cnt_r[k] <= C'(1);
      end
      kept_r     <= N'(1);
      slot_num_r <= '0;
      slot_den_r <= DW'(1);
    end else begin
      num_r      <= num_nxt;
      den_r      <= den_nxt;
      cnt_r      <= cnt_nxt;
      kept_r     <= kept_nxt;
      slot_num_r <= slot_num_nxt;
      slot_den_r <= slot_den_nxt;
    end
    mode_r   <= mode_nxt;
    dn_r     <= dn_nxt;
    dd_r     <= dd_nxt;
    ni_r     <= ni_nxt;
    di_r     <= di_nxt;
    drop_r   <= drop_nxt;
    p1_r     <= p1_nxt;
    p2_r     <= p2_nxt;
    nk_r     <= nk_nxt;
    bn_r     <= bn_nxt;
    bd_r     <= bd_nxt;
    best_v_r <= best_v_nxt;
    fired_r  <= fired_nxt;
    sat_r    <= sat_nxt;
    hit_r    <= hit_nxt;
    ga_r     <= ga_nxt;
    gb_r     <= gb_nxt;
    gk_r     <= gk_nxt;
    g_r      <= g_nxt;
    out_r    <= out_nxt;
  end

  always_comb begin
    sts.mode       = mode_r;
    sts.dn_zero    = (dn_r == '0);
    sts.kept_empty = (kept_r == '0);
    sts.on         = (num_r[idx] != '0);
    sts.kept       = kept_r[idx];
    sts.lt         = (p2_r < p1_r);
    sts.div_done   = div_done;
    sts.gcd_zero   = (ga_r == '0);
    sts.drop       = drop_r;
  end

  assign out_word = out_r;
endmodule

FILE: src/mtm_ctrl.sv
// Controller: sequences rebuild, advance and query over the datapath.
`timescale 1ns / 1ps
module mtm_ctrl #(
  parameter int NUM_PERIODS = mtm_pkg::NUM_PERIODS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  mtm_pkg::mtm_sts_t sts,
  output mtm_pkg::mtm_cmd_t cmd
);
  localparam int IDX_W = $clog2(NUM_PERIODS);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(NUM_PERIODS - 1);

  localparam logic [4:0] S_IDLE      = 5'd0;
  localparam logic [4:0] S_RB_ENTRY  = 5'd1;
  localparam logic [4:0] S_RB_PAIR   = 5'd2;
  localparam logic [4:0] S_RB_CHK    = 5'd3;
  localparam logic [4:0] S_RB_PWAIT  = 5'd4;
  localparam logic [4:0] S_RB_DECIDE = 5'd5;
  localparam logic [4:0] S_RB_REST   = 5'd6;
  localparam logic [4:0] S_RB_RGO    = 5'd7;
  localparam logic [4:0] S_RB_RWAIT  = 5'd8;
  localparam logic [4:0] S_RB_DROP   = 5'd9;
  localparam logic [4:0] S_DISPATCH  = 5'd10;
  localparam logic [4:0] S_P1_N      = 5'd11;
  localparam logic [4:0] S_P1_MUL    = 5'd12;
  localparam logic [4:0] S_P1_CMP    = 5'd13;
  localparam logic [4:0] S_P2_N      = 5'd14;
  localparam logic [4:0] S_P2_MUL    = 5'd15;
  localparam logic [4:0] S_P2_CMP    = 5'd16;
  localparam logic [4:0] S_G_GO      = 5'd17;
  localparam logic [4:0] S_G_WAIT    = 5'd18;
  localparam logic [4:0] S_G_STEP    = 5'd19;
  localparam logic [4:0] S_N_GO      = 5'd20;
  localparam logic [4:0] S_N_WAIT    = 5'd21;
  localparam logic [4:0] S_D_GO      = 5'd22;
  localparam logic [4:0] S_D_WAIT    = 5'd23;
  localparam logic [4:0] S_Q_MUL     = 5'd24;
  localparam logic [4:0] S_Q_GO      = 5'd25;
  localparam logic [4:0] S_Q_WAIT    = 5'd26;
  localparam logic [4:0] S_OUT       = 5'd27;

  logic [4:0]       state_r, state_nxt;
  logic [IDX_W-1:0] i_r, i_nxt;
  logic [IDX_W-1:0] j_r, j_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    cmd.op        = mtm_pkg::OP_NONE;
    cmd.idx       = mtm_pkg::IDX_MAX_W'(i_r);
    in_tready     = 1'b0;

    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.op    = mtm_pkg::OP_LOAD_IN;
          state_nxt = S_DISPATCH;
        end
      end
      S_RB_ENTRY: begin
        cmd.op = mtm_pkg::OP_RB_ENTRY;
        j_nxt  = '0;
        state_nxt = sts.on ? S_RB_PAIR : S_RB_DROP;
      end
      S_RB_PAIR: begin
        cmd.idx = mtm_pkg::IDX_MAX_W'(j_r);
        if (j_r == i_r || !sts.on) begin
          if (j_r == LAST) begin
            state_nxt = S_RB_DECIDE;
          end else begin
            j_nxt = j_r + 1'b1;
          end
        end else begin
          cmd.op    = mtm_pkg::OP_MUL_PAIR;
          state_nxt = S_RB_CHK;
        end
      end
      S_RB_CHK: begin
        if (sts.lt) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = mtm_pkg::DV_PROD;
          state_nxt     = S_RB_PWAIT;
        end else if (j_r == LAST) begin
          state_nxt = S_RB_DECIDE;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_RB_PAIR;
        end
      end
      S_RB_PWAIT: begin
        if (sts.div_done) begin
          cmd.op = mtm_pkg::OP_PAIR_DONE;
          if (j_r == LAST) begin
            state_nxt = S_RB_DECIDE;
          end else begin
            j_nxt     = j_r + 1'b1;
            state_nxt = S_RB_PAIR;
          end
        end
      end
      S_RB_DECIDE: begin
        state_nxt = sts.drop ? S_RB_DROP : S_RB_REST;
      end
      S_RB_REST: begin
        cmd.op    = mtm_pkg::OP_MUL_REST;
        state_nxt = S_RB_RGO;
      end
      S_RB_RGO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = mtm_pkg::DV_PROD;
        state_nxt     = S_RB_RWAIT;
      end
      S_RB_RWAIT: begin
        if (sts.div_done) begin
          cmd.op = mtm_pkg::OP_SET_KEEP;
          if (i_r == LAST) begin
            state_nxt = S_IDLE;
          end else begin
            i_nxt     = i_r + 1'b1;
            state_nxt = S_RB_ENTRY;
          end
        end
      end
      S_RB_DROP: begin
        cmd.op = mtm_pkg::OP_SET_DROP;
        if (i_r == LAST) begin
          state_nxt = S_IDLE;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_RB_ENTRY;
        end
      end
      S_DISPATCH: begin
        i_nxt = '0;
        if (sts.mode) begin
          state_nxt = sts.dn_zero ? S_OUT : S_Q_MUL;
        end else begin
          state_nxt = sts.kept_empty ? S_OUT : S_P1_N;
        end
      end
      S_P1_N, S_P2_N: begin
        if (sts.kept) begin
          cmd.op    = mtm_pkg::OP_MUL_N;
          state_nxt = (state_r == S_P1_N) ? S_P1_MUL : S_P2_MUL;
        end else if (i_r == LAST) begin
          i_nxt     = '0;
          state_nxt = (state_r == S_P1_N) ? S_P2_N : S_G_GO;
        end else begin
          i_nxt = i_r + 1'b1;
        end
      end
      S_P1_MUL: begin
        cmd.op    = mtm_pkg::OP_MUL_CMP;
        state_nxt = S_P1_CMP;
      end
      S_P2_MUL: begin
        cmd.op    = mtm_pkg::OP_MUL_CMP;
        state_nxt = S_P2_CMP;
      end
      S_P1_CMP, S_P2_CMP: begin
        cmd.op = (state_r == S_P1_CMP) ? mtm_pkg::OP_BEST : mtm_pkg::OP_FIRE;
        if (i_r == LAST) begin
          i_nxt     = '0;
          state_nxt = (state_r == S_P1_CMP) ? S_P2_N : S_G_GO;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = (state_r == S_P1_CMP) ? S_P1_N : S_P2_N;
        end
      end
      S_G_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = mtm_pkg::DV_GCD;
        state_nxt     = S_G_WAIT;
      end
      S_G_WAIT: begin
        cmd.div_sel = mtm_pkg::DV_GCD;
        if (sts.div_done) begin
          cmd.op    = mtm_pkg::OP_GCD_LOAD;
          state_nxt = S_G_STEP;
        end
      end
      S_G_STEP: begin
        if (sts.gcd_zero) begin
          cmd.op    = mtm_pkg::OP_GCD_FIN;
          state_nxt = S_N_GO;
        end else begin
          cmd.op = mtm_pkg::OP_GCD_STEP;
        end
      end
      S_N_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = mtm_pkg::DV_NUM;
        state_nxt     = S_N_WAIT;
      end
      S_N_WAIT: begin
        if (sts.div_done) begin
          cmd.op    = mtm_pkg::OP_NUM_DONE;
          state_nxt = S_D_GO;
        end
      end
      S_D_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = mtm_pkg::DV_DEN;
        state_nxt     = S_D_WAIT;
      end
      S_D_WAIT: begin
        if (sts.div_done) begin
          cmd.op    = mtm_pkg::OP_DEN_DONE;
          state_nxt = S_OUT;
        end
      end
      S_Q_MUL: begin
        cmd.op    = mtm_pkg::OP_MUL_QRY;
        state_nxt = S_Q_GO;
      end
      S_Q_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = mtm_pkg::DV_PROD;
        state_nxt     = S_Q_WAIT;
      end
      S_Q_WAIT: begin
        if (sts.div_done) begin
          cmd.op    = mtm_pkg::OP_QRY_DONE;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          cmd.op        = mtm_pkg::OP_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // restart the rebuild on every register write
    if (cfg_we) begin
      i_nxt     = '0;
      state_nxt = S_RB_ENTRY;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      i_r         <= '0;
      j_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
endmodule

FILE: src/multirate_timeslot_merger_top.sv
// Top level of the multirate timeslot merger.
`timescale 1ns / 1ps
// Merges up to NUM_PERIODS periodic streams with rational periods and walks
// the merged time slots. It takes one word at a time: an advance with kept
// entries runs two scans over the kept entries, a divide for the gcd seed,
// binary gcd steps, then two more divides to reduce the slot; a query with a
// nonzero delta_num runs one divide. All divides share one bit-serial divider.
// A register write starts a rebuild of the kept set that holds off input; a
// further write restarts it. The result register lets the next word in while
// a result waits.
module multirate_timeslot_merger_top #(
  parameter int NUM_PERIODS = mtm_pkg::NUM_PERIODS_DEF,
  parameter int PERIOD_BITS = mtm_pkg::PERIOD_BITS_DEF,
  parameter int COUNT_BITS  = mtm_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [mtm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mtm_pkg::REG_W-1:0]      cfg_wdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [mtm_pkg::IN_W-1:0]       in_tdata,   // delta_num, delta_den
  input  logic [0:0]                     in_tuser,   // mode
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // slot_num, slot_den, fired_mask, hit, status, zero pad
  output logic [mtm_pkg::OUT_W-1:0]      out_tdata
);
  mtm_pkg::mtm_cmd_t cmd;
  mtm_pkg::mtm_sts_t sts;

  mtm_ctrl #(
    .NUM_PERIODS (NUM_PERIODS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  mtm_dp #(
    .NUM_PERIODS (NUM_PERIODS),
    .PERIOD_BITS (PERIOD_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd       (cmd),
    .sts       (sts),
    .out_word  (out_tdata)
  );
endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for the multirate timeslot merger: predicted slots against stream words.
`timescale 1ns / 1ps
module tb_top;

  localparam logic MODE_ADVANCE = 1'b0;
  localparam logic MODE_QUERY   = 1'b1;
  localparam int   N_ENTRIES    = 4;
  localparam longint unsigned CNT_MAX = 64'h0000_0000_FFFF_FFFF;
  localparam int   SETTLE_CYCLES = 400;

  typedef struct packed {
    logic        mode;
    logic [15:0] delta_den;
    logic [15:0] delta_num;
  } tick_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        hit;
    logic [3:0]  fired_mask;
    logic [15:0] slot_den;
    logic [47:0] slot_num;
  } tick_res_t;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [mtm_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [mtm_pkg::REG_W-1:0]     cfg_wdata;
  logic                          in_tvalid;
  logic                          in_tready;
  logic [mtm_pkg::IN_W-1:0]      in_tdata;
  logic [0:0]                    in_tuser;
  logic                          out_tvalid;
  logic                          out_tready;
  logic [mtm_pkg::OUT_W-1:0]     out_tdata;

  multirate_timeslot_merger_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  tick_req_t       pending_ticks[$];
  tick_res_t       expected_slots[$];
  int              send_idle_pct;
  int              recv_stall_pct;
  int              err_count;
  int              n_adv, n_qry, n_hit, n_empty, n_sat, n_cfg;

  logic [15:0]     period_reg[8];
  longint unsigned slot_n, slot_d;
  longint unsigned occ_cnt[N_ENTRIES];
  logic [3:0]      kept;

  function automatic longint unsigned ent_num(int k);
    return longint'(period_reg[2*k]);
  endfunction

  function automatic longint unsigned ent_den(int k);
    return (period_reg[2*k+1] == 16'd0) ? 64'd1 : longint'(period_reg[2*k+1]);
  endfunction

  function automatic void rebuild_kept();
    longint unsigned ni, di, nj, dj, q;
    logic drop;
    kept = 4'd0;
    for (int i = 0; i < N_ENTRIES; i++) begin
      occ_cnt[i] = 1;
      if (ent_num(i) != 0) begin
        ni = ent_num(i);
        di = ent_den(i);
        drop = 1'b0;
        for (int j = 0; j < N_ENTRIES; j++) begin
          if (j != i && ent_num(j) != 0) begin
            nj = ent_num(j);
            dj = ent_den(j);
            if (nj * di < ni * dj && (ni * dj) % (di * nj) == 0) drop = 1'b1;
          end
        end
        if (!drop) begin
          q = (slot_n * di) / (slot_d * ni);
          kept[i] = 1'b1;
          occ_cnt[i] = (q >= CNT_MAX) ? CNT_MAX : q + 1;
        end
      end
    end
  endfunction

  function automatic void reset_merger();
    for (int k = 0; k < N_ENTRIES; k++) begin
      period_reg[2*k]   = (k == 0) ? 16'd1 : 16'd0;
      period_reg[2*k+1] = 16'd1;
      occ_cnt[k] = 1;
    end
    slot_n = 0;
    slot_d = 1;
    kept   = 4'b0001;
  endfunction

  function automatic tick_res_t predict_slot(tick_req_t req);
    tick_res_t r;
    longint unsigned bn, bd, n, d, a, b, t, dd;
    int best;
    r = '0;
    if (kept == 0) r.status = mtm_pkg::ST_EMPTY;
    if (req.mode == MODE_ADVANCE) begin
      if (kept != 0) begin
        best = -1;
        bn = 0;
        bd = 1;
        for (int k = 0; k < N_ENTRIES; k++) begin
          if (kept[k]) begin
            n = ent_num(k) * occ_cnt[k];
            d = ent_den(k);
            if (best < 0 || n * bd < bn * d) begin
              best = k;
              bn = n;
              bd = d;
            end
          end
        end
        for (int k = 0; k < N_ENTRIES; k++) begin
          if (kept[k]) begin
            n = ent_num(k) * occ_cnt[k];
            d = ent_den(k);
            if (n * bd == bn * d) begin
              r.fired_mask[k] = 1'b1;
              if (occ_cnt[k] >= CNT_MAX) r.status = mtm_pkg::ST_SAT;
              else occ_cnt[k]++;
            end
          end
        end
        a = bn;
        b = bd;
        while (b != 0) begin
          t = a % b;
          a = b;
          b = t;
        end
        slot_n = bn / a;
        slot_d = bd / a;
      end
    end else begin
      dd = (req.delta_den == 16'd0) ? 64'd1 : longint'(req.delta_den);
      if (req.delta_num != 0 && (slot_n * dd) % (slot_d * req.delta_num) == 0) r.hit = 1'b1;
    end
    r.slot_num = slot_n[47:0];
    r.slot_den = slot_d[15:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("mismatch %s: got 0x%0h expected 0x%0h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // clock and limit
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #60ms;
    $display("TB_ERROR");
    $finish;
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_slots.push_back(predict_slot(tick_req_t'({in_tuser, in_tdata})));
        if (in_tuser == MODE_ADVANCE) n_adv++;
        else n_qry++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          tick_req_t nx;
          nx = pending_ticks.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= nx.mode;
          in_tdata  <= {nx.delta_den, nx.delta_num};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        tick_res_t got, want;
        got = tick_res_t'(out_tdata[70:0]);
        if (expected_slots.size() == 0) begin
          report_mismatch("unexpected word", out_tdata[63:0], 64'd0);
        end else begin
          want = expected_slots.pop_front();
          if (got.slot_num !== want.slot_num) report_mismatch("slot_num", got.slot_num, want.slot_num);
          if (got.slot_den !== want.slot_den) report_mismatch("slot_den", got.slot_den, want.slot_den);
          if (got.fired_mask !== want.fired_mask)
            report_mismatch("fired_mask", got.fired_mask, want.fired_mask);
          if (got.hit !== want.hit) report_mismatch("hit", got.hit, want.hit);
          if (got.status !== want.status) report_mismatch("status", got.status, want.status);
          if (want.hit) n_hit++;
          if (want.status == mtm_pkg::ST_EMPTY) n_empty++;
          if (want.status == mtm_pkg::ST_SAT) n_sat++;
        end
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic drain();
    wait (pending_ticks.size() == 0 && !in_tvalid && expected_slots.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_period(int idx, logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx[mtm_pkg::CFG_IDX_W-1:0];
    cfg_wdata <= val;
    period_reg[idx] = val;
    rebuild_kept();
    n_cfg++;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_tick(logic mode, logic [15:0] dn, logic [15:0] dd);
    tick_req_t t;
    t.mode = mode;
    t.delta_num = dn;
    t.delta_den = dd;
    pending_ticks.push_back(t);
  endtask

  function automatic logic [15:0] rand_num();
    case ($urandom_range(9))
      0, 1:       return 16'd0;
      7:          return 16'hFFFF;
      8:          return 16'($urandom);
      default:    return 16'($urandom_range(12, 1));
    endcase
  endfunction

  function automatic logic [15:0] rand_den();
    case ($urandom_range(7))
      0:       return 16'd0;
      1:       return 16'($urandom);
      default: return 16'($urandom_range(6, 1));
    endcase
  endfunction

  function automatic logic [15:0] rand_delta_num();
    case ($urandom_range(7))
      0:       return 16'd0;
      1, 2:    return 16'($urandom);
      default: return 16'($urandom_range(12, 1));
    endcase
  endfunction

  initial begin
    int phase_items;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = '0;
    out_tready    = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    err_count = 0;
    n_adv = 0; n_qry = 0; n_hit = 0; n_empty = 0; n_sat = 0; n_cfg = 0;
    reset_merger();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset state: unit period
    push_tick(MODE_ADVANCE, 16'd0, 16'd0);
    push_tick(MODE_ADVANCE, 16'd0, 16'd0);
    push_tick(MODE_QUERY, 16'd0, 16'd1);
    push_tick(MODE_QUERY, 16'd1, 16'd0);
    push_tick(MODE_QUERY, 16'd2, 16'd1);
    push_tick(MODE_QUERY, 16'hFFFF, 16'hFFFF);
    drain();

    // equal periods fire together, a whole multiple is dropped
    write_period(2, 16'd3);
    write_period(3, 16'd2);
    write_period(4, 16'd3);
    write_period(5, 16'd0);
    write_period(6, 16'd1);
    write_period(7, 16'd1);
    repeat (4) push_tick(MODE_ADVANCE, 16'h5A5A, 16'hA5A5);
    push_tick(MODE_QUERY, 16'd3, 16'd2);
    push_tick(MODE_QUERY, 16'd5, 16'd7);
    drain();

    // empty set
    write_period(0, 16'd0);
    write_period(2, 16'd0);
    write_period(4, 16'd0);
    write_period(6, 16'd0);
    push_tick(MODE_ADVANCE, 16'd0, 16'd1);
    push_tick(MODE_QUERY, 16'd1, 16'd1);
    drain();

    // counter saturation after a huge restart value
    write_period(0, 16'hFFFF);
    write_period(1, 16'd1);
    push_tick(MODE_ADVANCE, 16'd0, 16'd1);
    push_tick(MODE_ADVANCE, 16'd0, 16'd1);
    drain();
    write_period(1, 16'hFFFF);
    write_period(0, 16'd1);
    push_tick(MODE_ADVANCE, 16'd0, 16'd1);
    push_tick(MODE_ADVANCE, 16'd0, 16'd1);
    push_tick(MODE_QUERY, 16'd1, 16'hFFFF);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      for (int r = 0; r < 8; r++) write_period(r, (r % 2 == 0) ? rand_num() : rand_den());
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      phase_items = 240;
      for (int n = 0; n < phase_items; n++) begin
        if ($urandom_range(99) < 55) push_tick(MODE_ADVANCE, 16'($urandom), 16'($urandom));
        else push_tick(MODE_QUERY, rand_delta_num(),
                       ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(6)));
      end
      drain();
    end

    $display("covered %0d advances, %0d queries (%0d hits), %0d register writes",
             n_adv, n_qry, n_hit, n_cfg);
    $display("empty-set words %0d, saturated words %0d", n_empty, n_sat);
    if (err_count == 0 && expected_slots.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
